// ===== rtl/assert_macros.svh =====
// assertion macros used by median_outlier_gate_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define MOG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// overlapping implication checked outside reset
`define MOG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define MOG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mog_pkg.sv =====
// shared types and constants of the median outlier gate
package mog_pkg;

   localparam int SAMPLE_W = 32;
   localparam int DEV_W    = 31;
   localparam int CSR_IDX_W = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [DEV_W-1:0]           dev_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;

   localparam csr_idx_type REG_UPPER_LIMIT       = 2'd0;
   localparam csr_idx_type REG_LOWER_LIMIT       = 2'd1;
   localparam csr_idx_type REG_ALLOWED_DEVIATION = 2'd2;

   localparam sample_type UPPER_RESET = 32'sh7FFF_FFFF;
   localparam sample_type LOWER_RESET = 32'sh8000_0000;
   localparam dev_type    DEV_RESET   = 31'h7FFF_FFFF;

   typedef struct packed {
      logic       sample_ok;
      sample_type median;
   } check_type;

endpackage

// ===== rtl/mog_rank.sv =====
// ranks one candidate entry against every ring entry in parallel
module mog_rank #(
   parameter int RING_DEPTH = 8
) (
   input  mog_pkg::sample_type candidate,
   input  mog_pkg::sample_type ring [RING_DEPTH],
   output logic                cand_zero,
   output logic [$clog2(RING_DEPTH+2)-1:0] abs_score
);

   localparam int CW = $clog2(RING_DEPTH + 2);

   logic [CW-1:0]        gt_count;
   logic [CW-1:0]        lt_count;
   logic signed [CW:0]   score;

   always_comb begin
      gt_count = '0;
      lt_count = '0;
      for (int j = 0; j < RING_DEPTH; j++) begin
         gt_count = gt_count + CW'(candidate > ring[j]);
         lt_count = lt_count + CW'(candidate < ring[j]);
      end
      score = $signed({1'b0, gt_count}) - $signed({1'b0, lt_count});
   end

   assign cand_zero = (candidate == '0);
   assign abs_score = score[CW] ? CW'(-score) : score[CW-1:0];

endmodule

// ===== rtl/mog_check.sv =====
// distance check of a sample against the chosen median
module mog_check (
   input  mog_pkg::sample_type sample,
   input  mog_pkg::sample_type median,
   input  logic                in_range,
   input  mog_pkg::dev_type    allowed_deviation,
   output mog_pkg::check_type  result
);

   logic signed [mog_pkg::SAMPLE_W:0] diff;
   logic [mog_pkg::SAMPLE_W:0]        abs_diff;

   always_comb begin
      diff     = {sample[mog_pkg::SAMPLE_W-1], sample} - {median[mog_pkg::SAMPLE_W-1], median};
      abs_diff = diff[mog_pkg::SAMPLE_W] ? -diff : diff;
      result.sample_ok = in_range && (abs_diff <= {2'b00, allowed_deviation});
      result.median    = in_range ? median : '0;
   end

endmodule

// ===== rtl/median_outlier_gate_top.sv =====
// Median outlier gate: each sample beat is written into a ring of the last RING_DEPTH
// samples and then checked against the ring's median. One comparator bank ranks one
// ring entry per cycle against all entries; an in-range sample passes the rank state,
// one step per ring entry, then the distance check, while an out-of-range sample goes
// straight to the check. The input stalls until the result is handed to the output
// register, so a new beat is not taken before the last one's result has reached it;
// that register holds the result while the next beat is taken in.
`include "assert_macros.svh"

module median_outlier_gate_top #(
   parameter int RING_DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_sample_ok,
   output logic                     rsp_ring_full,
   output logic signed [31:0]       rsp_median_seen,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data
);

   localparam int IW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW   = $clog2(RING_DEPTH + 2);
   localparam int HALF = RING_DEPTH / 2;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RANK  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;

   logic [1:0] state_ff, state_in;

   mog_pkg::sample_type ring_ff [RING_DEPTH];
   logic [IW-1:0]       slot_ff, slot_in;
   logic                wrapped_ff, wrapped_in;

   mog_pkg::sample_type upper_ff, lower_ff;
   mog_pkg::dev_type    dev_ff;

   mog_pkg::sample_type sample_ff, sample_in;
   logic                in_range_ff, in_range_in;
   logic                full_ff, full_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       zeros_ff, zeros_in;
   logic [CW-1:0]       best_ff, best_in;
   mog_pkg::sample_type med_ff, med_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                ok_ff;
   logic                full_out_ff;
   mog_pkg::sample_type med_out_ff;

   logic                req_beat;
   logic                out_free;
   logic                cand_zero;
   logic [CW-1:0]       abs_score;
   logic                last_wrap;
   logic                in_range_now;
   mog_pkg::check_type  check;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_beat  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign last_wrap    = (slot_ff == IW'(RING_DEPTH - 1));
   assign in_range_now = (req_sample <= upper_ff) && (req_sample >= lower_ff);

   mog_rank #(
      .RING_DEPTH (RING_DEPTH)
   ) u_rank (
      .candidate (ring_ff[idx_ff]),
      .ring      (ring_ff),
      .cand_zero (cand_zero),
      .abs_score (abs_score)
   );

   mog_check u_check (
      .sample            (sample_ff),
      .median            (med_ff),
      .in_range          (in_range_ff),
      .allowed_deviation (dev_ff),
      .result            (check)
   );

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      wrapped_in  = wrapped_ff;
      sample_in   = sample_ff;
      in_range_in = in_range_ff;
      full_in     = full_ff;
      idx_in      = idx_ff;
      zeros_in    = zeros_ff;
      best_in     = best_ff;
      med_in      = med_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               slot_in     = last_wrap ? '0 : slot_ff + 1'b1;
               wrapped_in  = wrapped_ff || last_wrap;
               sample_in   = req_sample;
               in_range_in = in_range_now;
               full_in     = wrapped_ff || last_wrap;
               idx_in      = '0;
               zeros_in    = '0;
               best_in     = CW'(RING_DEPTH + 1);
               med_in      = '0;
               state_in    = in_range_now ? ST_RANK : ST_CHECK;
            end
         end
         ST_RANK: begin
            zeros_in = zeros_ff + CW'(cand_zero);
            if (!cand_zero && (abs_score < best_ff)) begin
               best_in = abs_score;
               med_in  = ring_ff[idx_ff];
            end
            if (idx_ff == IW'(RING_DEPTH - 1)) begin
               if (zeros_in >= CW'(HALF)) begin
                  med_in = '0;
               end
               state_in = ST_CHECK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_CHECK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         upper_ff     <= mog_pkg::UPPER_RESET;
         lower_ff     <= mog_pkg::LOWER_RESET;
         dev_ff       <= mog_pkg::DEV_RESET;
         for (int k = 0; k < RING_DEPTH; k++) begin
            ring_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_beat) begin
            ring_ff[slot_ff] <= req_sample;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mog_pkg::REG_UPPER_LIMIT:       upper_ff <= csr_data;
               mog_pkg::REG_LOWER_LIMIT:       lower_ff <= csr_data;
               mog_pkg::REG_ALLOWED_DEVIATION: dev_ff   <= csr_data[mog_pkg::DEV_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      in_range_ff <= in_range_in;
      full_ff     <= full_in;
      idx_ff      <= idx_in;
      zeros_ff    <= zeros_in;
      best_ff     <= best_in;
      med_ff      <= med_in;
      if ((state_ff == ST_CHECK) && out_free) begin
         ok_ff       <= check.sample_ok;
         full_out_ff <= full_ff;
         med_out_ff  <= check.median;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_ok   = ok_ff;
   assign rsp_ring_full   = full_out_ff;
   assign rsp_median_seen = med_out_ff;

   // sequencing checks
   `MOG_ASSERT_NEXT(a_accept_busy, clock, reset, req_beat, state_ff != ST_IDLE, "accepted beat left sequencer idle")
   `MOG_ASSERT_IMP(a_rsp_from_check, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_CHECK, "result appeared outside check")
   `MOG_ASSERT(a_slot_range, clock, reset, slot_ff <= IW'(RING_DEPTH - 1), "write slot beyond ring")
   `MOG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(ok_ff) && $stable(full_out_ff) && $stable(med_out_ff), "stalled result beat changed")

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the median outlier gate: random and directed samples
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = 8;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 255;
   localparam int HOLD_AFTER = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int STUCK_LIMIT = 2000;
   localparam mog_pkg::csr_idx_type REG_NONE = 2'd3;

   localparam mog_pkg::sample_type WIDE_SET [13] = '{
      32'sh0, 32'sh0, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
      32'sh8000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh1, -32'sh1,
      32'sh8000_0000, 32'sh7FFF_FFFF};
   localparam mog_pkg::sample_type TIGHT_SET [7] = '{
      32'sh0002_0000, -32'sh0002_0000, 32'sh0001_0000, -32'sh0001_0000,
      32'sh0001_0001, 32'sh0000_4000, 32'sh0000_C000};
   localparam mog_pkg::sample_type CROSSED_SET [5] = '{32'sh0, 32'sh3, -32'sh3, 32'sh5, -32'sh5};

   typedef struct packed {
      logic                ok;
      logic                full;
      mog_pkg::sample_type median;
   } verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   mog_pkg::sample_type  req_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_sample_ok;
   logic                 rsp_ring_full;
   mog_pkg::sample_type  rsp_median_seen;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   mog_pkg::csr_idx_type csr_index = '0;
   logic [31:0]          csr_data = '0;

   mog_pkg::sample_type  hist [RING_DEPTH] = '{default: '0};
   int unsigned          hist_slot = 0;
   logic                 hist_wrapped = 1'b0;
   mog_pkg::sample_type  cfg_upper = mog_pkg::UPPER_RESET;
   mog_pkg::sample_type  cfg_lower = mog_pkg::LOWER_RESET;
   mog_pkg::dev_type     cfg_dev = mog_pkg::DEV_RESET;

   mog_pkg::sample_type  samples_to_send[$];
   verdict_type          verdicts_due[$];
   int          queued_count = 0;
   int          checked_count = 0;
   int          passed_count = 0;
   int          full_count = 0;
   int          settings_count = 1;
   int          errors = 0;
   int          req_gap_pct = 0;
   int          rsp_stall_pct = 0;

   median_outlier_gate_top #(.RING_DEPTH(RING_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample_ok   (rsp_sample_ok),
      .rsp_ring_full   (rsp_ring_full),
      .rsp_median_seen (rsp_median_seen),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #5 clock = ~clock;

   function automatic mog_pkg::sample_type ring_median();
      int zeros;
      int score;
      int best;
      mog_pkg::sample_type med;
      zeros = 0;
      best = RING_DEPTH + 1;
      med = '0;
      foreach (hist[i]) if (hist[i] == 0) zeros++;
      if (zeros >= RING_DEPTH / 2) return '0;
      foreach (hist[i]) begin
         if (hist[i] != 0) begin
            score = 0;
            foreach (hist[j]) begin
               if (j != i) begin
                  if (hist[i] > hist[j]) score++;
                  else if (hist[i] < hist[j]) score--;
               end
            end
            if (score < 0) score = -score;
            if (score < best) begin
               best = score;
               med = hist[i];
            end
         end
      end
      return med;
   endfunction

   function automatic verdict_type gate_sample(mog_pkg::sample_type s);
      verdict_type v;
      longint diff;
      hist[hist_slot] = s;
      hist_slot = (hist_slot + 1) % RING_DEPTH;
      if (hist_slot == 0) hist_wrapped = 1'b1;
      v.ok = 1'b0;
      v.full = hist_wrapped;
      v.median = '0;
      if (s <= cfg_upper && s >= cfg_lower) begin
         v.median = ring_median();
         diff = longint'(s) - longint'(v.median);
         if (diff < 0) diff = -diff;
         v.ok = (diff <= longint'(cfg_dev));
      end
      return v;
   endfunction

   function automatic int draw_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
   endfunction

   function automatic int draw_gap(int pct);
      return ($urandom_range(0, 99) < pct) ? draw_len() : 0;
   endfunction

   task automatic queue_sample(mog_pkg::sample_type s);
      samples_to_send.push_back(s);
      queued_count++;
   endtask

   task automatic write_reg(mog_pkg::csr_idx_type idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mog_pkg::REG_UPPER_LIMIT: cfg_upper = data;
         mog_pkg::REG_LOWER_LIMIT: cfg_lower = data;
         mog_pkg::REG_ALLOWED_DEVIATION: cfg_dev = data[mog_pkg::DEV_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_limits(mog_pkg::sample_type up, mog_pkg::sample_type lo,
                             logic [31:0] dev_word);
      write_reg(mog_pkg::REG_UPPER_LIMIT, up);
      write_reg(mog_pkg::REG_LOWER_LIMIT, lo);
      write_reg(mog_pkg::REG_ALLOWED_DEVIATION, dev_word);
      write_reg(REG_NONE, $urandom);
      settings_count++;
   endtask

   task automatic wait_drained();
      while (checked_count != queued_count) @(posedge clock);
   endtask

   // sample driver
   always @(posedge clock) begin
      int gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) verdicts_due.push_back(gate_sample(req_sample));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (samples_to_send.size() > 0) begin
               req_valid <= 1'b1;
               req_sample <= samples_to_send.pop_front();
               gap_left = draw_gap(req_gap_pct);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall, with one long hold-off
   always @(posedge clock) begin
      int stall_run;
      int hold_left;
      bit hold_done;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && checked_count >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         stall_run = draw_len();
      end
   end

   // result monitor
   always @(posedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (rsp_sample_ok) passed_count++;
         if (rsp_ring_full) full_count++;
         if (verdicts_due.size() == 0) begin
            $error("result beat with no sample outstanding: ok=%0b full=%0b median=%0h",
                   rsp_sample_ok, rsp_ring_full, rsp_median_seen);
            errors++;
         end else begin
            exp_v = verdicts_due.pop_front();
            if (rsp_sample_ok !== exp_v.ok) begin
               $error("sample_ok: expected %0b, actual %0b", exp_v.ok, rsp_sample_ok);
               errors++;
            end
            if (rsp_ring_full !== exp_v.full) begin
               $error("ring_full: expected %0b, actual %0b", exp_v.full, rsp_ring_full);
               errors++;
            end
            if (rsp_median_seen !== exp_v.median) begin
               $error("median_seen: expected %0h, actual %0h", exp_v.median, rsp_median_seen);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      int stuck;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck = 0;
      else
         stuck++;
      if (stuck >= STUCK_LIMIT) begin
         $error("no beat moved for %0d cycles, %0d results outstanding", stuck,
                queued_count - checked_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      mog_pkg::sample_type center;
      mog_pkg::sample_type up;
      mog_pkg::sample_type lo;
      mog_pkg::sample_type s;
      logic [31:0] span;
      logic [31:0] dev_word;
      mog_pkg::sample_type recent [8];
      recent = '{default: '0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, out of range, crossed limits
      req_gap_pct = 20;
      rsp_stall_pct = 20;
      foreach (WIDE_SET[i]) queue_sample(WIDE_SET[i]);
      wait_drained();
      set_limits(32'sh0001_0000, -32'sh0001_0000, 32'h0000_8000);
      foreach (TIGHT_SET[i]) queue_sample(TIGHT_SET[i]);
      wait_drained();
      set_limits(-32'sh5, 32'sh5, 32'h7FFF_FFFF);
      foreach (CROSSED_SET[i]) queue_sample(CROSSED_SET[i]);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         center = $urandom;
         span = $urandom_range(256, 1 << 22);
         case (p)
            0: begin
               up = 32'sh7FFF_FFFF;
               lo = 32'sh8000_0000;
               dev_word = 32'hFFFF_FFFF;
            end
            1: begin
               up = center + span;
               lo = center - span;
               dev_word = $urandom_range(0, span);
            end
            2: begin
               up = 32'sh7FFF_FFFF;
               lo = 32'sh8000_0000;
               dev_word = '0;
            end
            3: begin
               up = 32'sh8000_0000;
               lo = 32'sh8000_0000;
               dev_word = $urandom;
            end
            4: begin
               up = center - span;
               lo = center + span;
               dev_word = $urandom;
            end
            default: begin
               up = $urandom;
               lo = $urandom;
               if (lo > up) lo = up - span;
               dev_word = ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, span);
            end
         endcase
         set_limits(up, lo, dev_word);
         req_gap_pct = (p == 2) ? 0 : (p == 4) ? 60 : 25;
         rsp_stall_pct = (p == 2) ? 0 : (p == 4) ? 60 : 30;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            case ($urandom_range(0, 19))
               0, 1, 2: s = '0;
               3, 4, 5, 6, 7, 8, 9, 10:
                  s = center + mog_pkg::sample_type'($urandom_range(0, 2 * span)) - span;
               11, 12, 13: s = recent[$urandom_range(0, 7)];
               14, 15, 16: s = $urandom;
               17: s = ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
               18: s = ($urandom_range(0, 1)) ? 32'sh1 : -32'sh1;
               default: begin
                  case ($urandom_range(0, 3))
                     0: s = cfg_upper;
                     1: s = cfg_upper + 1;
                     2: s = cfg_lower;
                     default: s = cfg_lower - 1;
                  endcase
               end
            endcase
            recent[k % 8] = s;
            queue_sample(s);
         end
         wait_drained();
      end

      repeat (2 * (RING_DEPTH + 2)) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         $error("%0d expected results never arrived", verdicts_due.size());
         errors++;
      end
      $display("covered %0d samples under %0d limit settings: %0d let through, %0d rejected",
               checked_count, settings_count, passed_count, checked_count - passed_count);
      $display("ring reported full on %0d results, %0d mismatches found", full_count, errors);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
